/* sv/qtm_pkg.sv */
// Shared types and constants for the quaternion TRS to matrix block.
// Depends on nothing; included by every other file of the block.
`timescale 1ns / 1ps

package qtm_pkg;

  localparam int QW    = 16;
  localparam int SW    = 32;
  localparam int PW    = 2 * QW;
  localparam int HW    = PW + 1;
  localparam int HFRAC = 27;
  localparam int HLW   = 16;
  localparam int PPW   = (HW - HLW) + SW;
  localparam int SUMW  = 65;

  localparam logic signed [HW-1:0]   HALF_ONE   = 33'sd134217728;
  localparam logic signed [SUMW-1:0] ROUND_BIAS = 65'sd67108864;
  localparam logic signed [SUMW-1:0] SAT_MAX    = 65'sd2147483647;
  localparam logic signed [SUMW-1:0] SAT_MIN    = -65'sd2147483648;

  typedef logic [1:0] col_t;

  localparam col_t COL_X = 2'd0;
  localparam col_t COL_Y = 2'd1;
  localparam col_t COL_Z = 2'd2;
  localparam col_t COL_T = 2'd3;

  typedef struct packed {
    logic valid;
    col_t col;
  } stage_ctrl_t;

endpackage

/* sv/qtm_entry_scale.sv */
// Two-stage scaling of one rotation half-term by an axis scale, with rounding
// and saturation to 32 bits. Depends on qtm_pkg.
`timescale 1ns / 1ps

module qtm_entry_scale (
  input  logic                            clk_i,
  input  logic signed [qtm_pkg::HW-1:0]   h_i,
  input  logic signed [qtm_pkg::SW-1:0]   scale_i,
  output logic signed [qtm_pkg::SW-1:0]   entry_o
);
  import qtm_pkg::*;

  logic signed [HW-HLW-1:0] h_lo;
  logic signed [HW-HLW-1:0] h_hi;
  logic signed [PPW-1:0]    lo_d, lo_q;
  logic signed [PPW-1:0]    hi_d, hi_q;
  logic signed [SUMW-1:0]   sum_d, sum_q;
  logic signed [SUMW-1:0]   quot;

  // The 33-bit term is split so that each multiplier stays near 17 by 32 bits.
  assign h_lo = $signed({1'b0, h_i[HLW-1:0]});
  assign h_hi = h_i[HW-1:HLW];
  assign lo_d = h_lo * scale_i;
  assign hi_d = h_hi * scale_i;

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign sum_d = (SUMW'(hi_q) <<< HLW) + SUMW'(lo_q) + ROUND_BIAS;

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // An arithmetic shift floors, which with the bias rounds ties upward.
  assign quot = sum_q >>> HFRAC;

  always_comb begin
    if (quot > SAT_MAX) begin
      entry_o = SW'(SAT_MAX);
    end else if (quot < SAT_MIN) begin
      entry_o = SW'(SAT_MIN);
    end else begin
      entry_o = SW'(quot);
    end
  end

endmodule

/* sv/quaternion_trs_to_matrix_top.sv */
// Each accepted transaction yields four columns on valid_o, from column 0 to column 3.
// The four column results leave on consecutive cycles; busy_o is high from each accepted
// transaction until the sequencer reaches column 3, when the next one can be accepted.
// The column sequencer feeds one column per cycle into the five-stage datapath.
// Reset clears the sequencer and all valid bits; valid_o stays low until the first result.
// Top level of the quaternion TRS to matrix block; depends on qtm_pkg and qtm_entry_scale.
`timescale 1ns / 1ps

module quaternion_trs_to_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [qtm_pkg::QW-1:0] quat_x_i,
  input  logic signed [qtm_pkg::QW-1:0] quat_y_i,
  input  logic signed [qtm_pkg::QW-1:0] quat_z_i,
  input  logic signed [qtm_pkg::QW-1:0] quat_w_i,
  input  logic signed [qtm_pkg::SW-1:0] scale_x_i,
  input  logic signed [qtm_pkg::SW-1:0] scale_y_i,
  input  logic signed [qtm_pkg::SW-1:0] scale_z_i,
  input  logic signed [qtm_pkg::SW-1:0] trans_x_i,
  input  logic signed [qtm_pkg::SW-1:0] trans_y_i,
  input  logic signed [qtm_pkg::SW-1:0] trans_z_i,
  output logic                          valid_o,
  output qtm_pkg::col_t                 column_o,
  output logic signed [qtm_pkg::SW-1:0] entry_row0_o,
  output logic signed [qtm_pkg::SW-1:0] entry_row1_o,
  output logic signed [qtm_pkg::SW-1:0] entry_row2_o,
  output logic signed [qtm_pkg::SW-1:0] entry_row3_o,
  output logic                          last_o
);
  import qtm_pkg::*;

  localparam logic signed [SW-1:0] ONE_Q = SW'(64'd1 << FRAC_BITS);

  logic accept;
  logic active_q, active_d;
  col_t cnt_q, cnt_d;

  logic signed [QW-1:0] in_x_q, in_y_q, in_z_q, in_w_q;
  logic signed [SW-1:0] in_scale_q [3];
  logic signed [SW-1:0] in_trans_q [3];

  stage_ctrl_t a_ctrl_q, b_ctrl_q, c_ctrl_q, d_ctrl_q;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [SW-1:0] a_scale_d, a_scale_q, b_scale_q;
  logic signed [SW-1:0] a_trans_q [3];
  logic signed [SW-1:0] b_trans_q [3];
  logic signed [SW-1:0] c_trans_q [3];
  logic signed [SW-1:0] d_trans_q [3];
  logic signed [HW-1:0] h_d [3];
  logic signed [HW-1:0] h_q [3];
  logic signed [SW-1:0] rot_entry [3];

  logic                 valid_q;
  col_t                 column_q;
  logic signed [SW-1:0] row_q [4];
  logic signed [SW-1:0] row_d [4];
  logic                 last_q;

  assign busy_o = active_q && (cnt_q != COL_T);
  assign accept = start_i && !busy_o;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (accept) begin
      active_d = 1'b1;
      cnt_d    = COL_X;
    end else if (active_q) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == COL_T) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= COL_X;
      a_ctrl_q <= '0;
      b_ctrl_q <= '0;
      c_ctrl_q <= '0;
      d_ctrl_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      a_ctrl_q <= '{valid: active_q, col: cnt_q};
      b_ctrl_q <= a_ctrl_q;
      c_ctrl_q <= b_ctrl_q;
      d_ctrl_q <= c_ctrl_q;
      valid_q  <= d_ctrl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_x_q        <= quat_x_i;
      in_y_q        <= quat_y_i;
      in_z_q        <= quat_z_i;
      in_w_q        <= quat_w_i;
      in_scale_q[0] <= scale_x_i;
      in_scale_q[1] <= scale_y_i;
      in_scale_q[2] <= scale_z_i;
      in_trans_q[0] <= trans_x_i;
      in_trans_q[1] <= trans_y_i;
      in_trans_q[2] <= trans_z_i;
    end
  end

  always_comb begin
    case (cnt_q)
      COL_X:   a_scale_d = in_scale_q[0];
      COL_Y:   a_scale_d = in_scale_q[1];
      default: a_scale_d = in_scale_q[2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    xx_q      <= in_x_q * in_x_q;
    yy_q      <= in_y_q * in_y_q;
    zz_q      <= in_z_q * in_z_q;
    xy_q      <= in_x_q * in_y_q;
    xz_q      <= in_x_q * in_z_q;
    yz_q      <= in_y_q * in_z_q;
    wx_q      <= in_w_q * in_x_q;
    wy_q      <= in_w_q * in_y_q;
    wz_q      <= in_w_q * in_z_q;
    a_scale_q <= a_scale_d;
    a_trans_q <= in_trans_q;
  end

  always_comb begin
    case (a_ctrl_q.col)
      COL_X: begin
        h_d[0] = HALF_ONE - (HW'(yy_q) + HW'(zz_q));
        h_d[1] = HW'(xy_q) + HW'(wz_q);
        h_d[2] = HW'(xz_q) - HW'(wy_q);
      end
      COL_Y: begin
        h_d[0] = HW'(xy_q) - HW'(wz_q);
        h_d[1] = HALF_ONE - (HW'(xx_q) + HW'(zz_q));
        h_d[2] = HW'(yz_q) + HW'(wx_q);
      end
      default: begin
        h_d[0] = HW'(xz_q) + HW'(wy_q);
        h_d[1] = HW'(yz_q) - HW'(wx_q);
        h_d[2] = HALF_ONE - (HW'(xx_q) + HW'(yy_q));
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    b_scale_q <= a_scale_q;
    b_trans_q <= a_trans_q;
    c_trans_q <= b_trans_q;
    d_trans_q <= c_trans_q;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    qtm_entry_scale u_entry (
      .clk_i   (clk_i),
      .h_i     (h_q[r]),
      .scale_i (b_scale_q),
      .entry_o (rot_entry[r])
    );
  end

  always_comb begin
    if (d_ctrl_q.col == COL_T) begin
      row_d[0] = d_trans_q[0];
      row_d[1] = d_trans_q[1];
      row_d[2] = d_trans_q[2];
      row_d[3] = ONE_Q;
    end else begin
      row_d[0] = rot_entry[0];
      row_d[1] = rot_entry[1];
      row_d[2] = rot_entry[2];
      row_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ctrl_q.valid) begin
      column_q <= d_ctrl_q.col;
      row_q    <= row_d;
      last_q   <= (d_ctrl_q.col == COL_T);
    end
  end

  assign valid_o      = valid_q;
  assign column_o     = column_q;
  assign entry_row0_o = row_q[0];
  assign entry_row1_o = row_q[1];
  assign entry_row2_o = row_q[2];
  assign entry_row3_o = row_q[3];
  assign last_o       = last_q;

  a_accept_starts_col0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (active_q && (cnt_q == COL_X)))
    else $error("accepted transaction did not start at column 0");

  a_columns_in_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (column_o != COL_T)) |=> (valid_o && (column_o == $past(column_o) + 2'd1)))
    else $error("column results not on consecutive cycles");

  a_last_on_col3 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o == (column_o == COL_T)))
    else $error("last does not match column 3");

  a_row3_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (column_o == COL_T)) |-> (entry_row3_o == ONE_Q))
    else $error("bottom entry of translation column is not one");

endmodule

/* tb/tb_quaternion_trs_to_matrix_top.sv */
// Self-checking testbench for quaternion_trs_to_matrix_top: directed and random node transforms,
// each checked column by column against a local fixed-point matrix predictor.
// Depends on qtm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_quaternion_trs_to_matrix_top;
  import qtm_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int ROT_FRAC = 27;
  localparam longint HALF_UNIT = 64'sd1 << ROT_FRAC;
  localparam longint ROUND_HALF = 64'sd1 << (ROT_FRAC - 1);
  localparam longint ENTRY_MAX = 64'sd2147483647;
  localparam longint ENTRY_MIN = -64'sd2147483648;
  localparam logic signed [SW-1:0] Q16_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [SW-1:0] Q16_MAX = 32'sh7fffffff;
  localparam logic signed [SW-1:0] Q16_MIN = 32'sh80000000;
  localparam logic signed [QW-1:0] QUAT_ONE = 16'sd16384;
  localparam logic signed [QW-1:0] QUAT_MAX = 16'sh7fff;
  localparam logic signed [QW-1:0] QUAT_MIN = 16'sh8000;
  localparam logic signed [QW-1:0] QUAT_HALF_TURN = 16'sd11585;
  localparam col_t ROT_COLUMNS [3] = '{COL_X, COL_Y, COL_Z};

  typedef struct {
    logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [SW-1:0] scale_x, scale_y, scale_z;
    logic signed [SW-1:0] trans_x, trans_y, trans_z;
  } node_transform_t;

  typedef struct {
    col_t                 column;
    logic signed [SW-1:0] row0, row1, row2, row3;
    logic                 last;
  } matrix_column_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic signed [QW-1:0] quat_x_i, quat_y_i, quat_z_i, quat_w_i;
  logic signed [SW-1:0] scale_x_i, scale_y_i, scale_z_i;
  logic signed [SW-1:0] trans_x_i, trans_y_i, trans_z_i;
  logic                 valid_o;
  col_t                 column_o;
  logic signed [SW-1:0] entry_row0_o, entry_row1_o, entry_row2_o, entry_row3_o;
  logic                 last_o;

  matrix_column_t expected_columns [$];
  int  mismatch_count = 0;
  int  transforms_sent = 0;
  int  columns_checked = 0;
  bit  sender_idles = 1'b1;

  quaternion_trs_to_matrix_top #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .quat_w_i    (quat_w_i),
    .scale_x_i   (scale_x_i),
    .scale_y_i   (scale_y_i),
    .scale_z_i   (scale_z_i),
    .trans_x_i   (trans_x_i),
    .trans_y_i   (trans_y_i),
    .trans_z_i   (trans_z_i),
    .valid_o     (valid_o),
    .column_o    (column_o),
    .entry_row0_o(entry_row0_o),
    .entry_row1_o(entry_row1_o),
    .entry_row2_o(entry_row2_o),
    .entry_row3_o(entry_row3_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [SW-1:0] scaled_rotation_entry(longint half_term,
                                                                  longint scale);
    longint rounded;
    rounded = (half_term * scale + ROUND_HALF) >>> ROT_FRAC;
    if (rounded > ENTRY_MAX) begin
      rounded = ENTRY_MAX;
    end else if (rounded < ENTRY_MIN) begin
      rounded = ENTRY_MIN;
    end
    return rounded[SW-1:0];
  endfunction

  function automatic void push_expected_matrix(node_transform_t t);
    longint qx, qy, qz, qw;
    longint scale [3];
    longint half_term [3][3];
    matrix_column_t col;
    qx = t.quat_x;
    qy = t.quat_y;
    qz = t.quat_z;
    qw = t.quat_w;
    scale[0] = t.scale_x;
    scale[1] = t.scale_y;
    scale[2] = t.scale_z;
    half_term[0][0] = HALF_UNIT - (qy * qy + qz * qz);
    half_term[0][1] = qx * qy + qw * qz;
    half_term[0][2] = qx * qz - qw * qy;
    half_term[1][0] = qx * qy - qw * qz;
    half_term[1][1] = HALF_UNIT - (qx * qx + qz * qz);
    half_term[1][2] = qy * qz + qw * qx;
    half_term[2][0] = qx * qz + qw * qy;
    half_term[2][1] = qy * qz - qw * qx;
    half_term[2][2] = HALF_UNIT - (qx * qx + qy * qy);
    for (int c = 0; c < 3; c++) begin
      col.column = ROT_COLUMNS[c];
      col.row0 = scaled_rotation_entry(half_term[c][0], scale[c]);
      col.row1 = scaled_rotation_entry(half_term[c][1], scale[c]);
      col.row2 = scaled_rotation_entry(half_term[c][2], scale[c]);
      col.row3 = '0;
      col.last = 1'b0;
      expected_columns.push_back(col);
    end
    col.column = COL_T;
    col.row0 = t.trans_x;
    col.row1 = t.trans_y;
    col.row2 = t.trans_z;
    col.row3 = Q16_ONE;
    col.last = 1'b1;
    expected_columns.push_back(col);
  endfunction

  function automatic node_transform_t make_transform(
      logic signed [QW-1:0] qx, logic signed [QW-1:0] qy,
      logic signed [QW-1:0] qz, logic signed [QW-1:0] qw,
      logic signed [SW-1:0] sx, logic signed [SW-1:0] sy, logic signed [SW-1:0] sz,
      logic signed [SW-1:0] tx, logic signed [SW-1:0] ty, logic signed [SW-1:0] tz);
    node_transform_t t;
    t.quat_x = qx;
    t.quat_y = qy;
    t.quat_z = qz;
    t.quat_w = qw;
    t.scale_x = sx;
    t.scale_y = sy;
    t.scale_z = sz;
    t.trans_x = tx;
    t.trans_y = ty;
    t.trans_z = tz;
    return t;
  endfunction

  function automatic logic signed [QW-1:0] random_quat_part();
    case ($urandom_range(0, 3))
      0: return QW'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return QUAT_MIN;
          1: return QUAT_MAX;
          2: return '0;
          3: return QUAT_ONE;
          default: return -QUAT_ONE;
        endcase
      end
      default: return QW'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] random_q16();
    case ($urandom_range(0, 3))
      0: return SW'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return Q16_MIN;
          1: return Q16_MAX;
          2: return '0;
          3: return Q16_ONE;
          default: return -Q16_ONE;
        endcase
      end
      default: return SW'($urandom_range(0, 1 << 18) - (1 << 17));
    endcase
  endfunction

  function automatic node_transform_t random_transform();
    return make_transform(random_quat_part(), random_quat_part(), random_quat_part(),
                          random_quat_part(), random_q16(), random_q16(), random_q16(),
                          random_q16(), random_q16(), random_q16());
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    mismatch_count++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic send_transform(node_transform_t t);
    int gap;
    gap = sender_idles ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    quat_x_i <= t.quat_x;
    quat_y_i <= t.quat_y;
    quat_z_i <= t.quat_z;
    quat_w_i <= t.quat_w;
    scale_x_i <= t.scale_x;
    scale_y_i <= t.scale_y;
    scale_z_i <= t.scale_z;
    trans_x_i <= t.trans_x;
    trans_y_i <= t.trans_y;
    trans_z_i <= t.trans_z;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    push_expected_matrix(t);
    transforms_sent++;
  endtask

  task automatic wait_for_all_columns();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_columns.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    matrix_column_t want;
    if (rst_ni && $isunknown(valid_o)) begin
      report_mismatch("valid_o known", 1, 0);
    end else if (rst_ni && valid_o) begin
      if (expected_columns.size() == 0) begin
        report_mismatch("column with no transaction outstanding", -1, column_o);
      end else begin
        want = expected_columns.pop_front();
        columns_checked++;
        if (column_o !== want.column) report_mismatch("column", want.column, column_o);
        if (entry_row0_o !== want.row0) report_mismatch("entry_row0", want.row0, entry_row0_o);
        if (entry_row1_o !== want.row1) report_mismatch("entry_row1", want.row1, entry_row1_o);
        if (entry_row2_o !== want.row2) report_mismatch("entry_row2", want.row2, entry_row2_o);
        if (entry_row3_o !== want.row3) report_mismatch("entry_row3", want.row3, entry_row3_o);
        if (last_o !== want.last) report_mismatch("last", want.last, last_o);
      end
    end
  end

  task automatic test_rotation_cases();
    send_transform(make_transform(0, 0, 0, QUAT_ONE, Q16_ONE, Q16_ONE, Q16_ONE,
                                  32'sd65536, -32'sd131072, 32'sd12345));
    send_transform(make_transform(QUAT_ONE, 0, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE, 0, 0, 0));
    send_transform(make_transform(0, QUAT_ONE, 0, 0, Q16_ONE, 32'sd131072, Q16_ONE, 0, 0, 0));
    send_transform(make_transform(0, 0, QUAT_ONE, 0, Q16_ONE, Q16_ONE, -Q16_ONE, 0, 0, 0));
    send_transform(make_transform(0, 0, QUAT_HALF_TURN, QUAT_HALF_TURN, 32'sd98304,
                                  32'sd32768, Q16_ONE, 0, 0, 0));
    send_transform(make_transform(0, 0, 0, -QUAT_ONE, Q16_ONE, Q16_ONE, Q16_ONE, 0, 0, 0));
    send_transform(make_transform(0, 0, 0, 0, 32'sd3, -32'sd7, Q16_ONE, 0, 0, 0));
    wait_for_all_columns();
  endtask

  task automatic test_saturation_extremes();
    send_transform(make_transform(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX,
                                  Q16_MAX, Q16_MAX, Q16_MAX, 0, 0, 0));
    send_transform(make_transform(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN,
                                  Q16_MIN, Q16_MIN, Q16_MIN, 0, 0, 0));
    send_transform(make_transform(QUAT_MIN, QUAT_MAX, QUAT_MIN, QUAT_MAX,
                                  Q16_MAX, Q16_MIN, 0, 0, 0, 0));
    send_transform(make_transform(QUAT_MIN, QUAT_MIN, QUAT_MIN, 0,
                                  Q16_MAX, Q16_MIN, Q16_MAX, 0, 0, 0));
    send_transform(make_transform(0, 0, 0, QUAT_MAX, Q16_MAX, Q16_MIN, -32'sd1, 0, 0, 0));
    send_transform(make_transform(QUAT_MAX, QUAT_MIN, 16'sd1, -16'sd1,
                                  32'sd1, -32'sd1, Q16_MIN, 0, 0, 0));
    send_transform(make_transform(16'sd1, -16'sd1, QUAT_MAX, QUAT_MIN,
                                  -Q16_ONE, Q16_MAX, 32'sd1, 0, 0, 0));
    wait_for_all_columns();
  endtask

  task automatic test_translation_passthrough();
    send_transform(make_transform(0, 0, 0, QUAT_ONE, Q16_ONE, Q16_ONE, Q16_ONE,
                                  Q16_MAX, Q16_MIN, 0));
    send_transform(make_transform(0, 0, 0, QUAT_ONE, Q16_ONE, Q16_ONE, Q16_ONE,
                                  Q16_MIN, 0, Q16_MAX));
    send_transform(make_transform(0, 0, 0, QUAT_ONE, Q16_ONE, Q16_ONE, Q16_ONE,
                                  -32'sd1, 32'sh55555555, 32'shaaaaaaaa));
    send_transform(make_transform(QUAT_MAX, 0, QUAT_MIN, 0, Q16_MAX, Q16_MAX, Q16_MAX,
                                  32'shaaaaaaaa, -32'sd1, 32'sh55555555));
    wait_for_all_columns();
  endtask

  task automatic test_back_to_back();
    sender_idles = 1'b0;
    repeat (12) send_transform(random_transform());
    wait_for_all_columns();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_transforms(int count);
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) sender_idles = $urandom_range(0, 2) != 0;
      send_transform(random_transform());
      if (n % 30 == 29) wait_for_all_columns();
    end
    wait_for_all_columns();
    sender_idles = 1'b1;
  endtask

  initial begin
    rst_ni    <= 1'b0;
    start_i   <= 1'b0;
    quat_x_i  <= '0;
    quat_y_i  <= '0;
    quat_z_i  <= '0;
    quat_w_i  <= '0;
    scale_x_i <= '0;
    scale_y_i <= '0;
    scale_z_i <= '0;
    trans_x_i <= '0;
    trans_y_i <= '0;
    trans_z_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rotation_cases();
    test_saturation_extremes();
    test_translation_passthrough();
    test_back_to_back();
    test_random_transforms(90);

    repeat (12) @(posedge clk_i);
    $display("Covered identity, axis and unnormalized rotations, saturation and translation");
    $display("extremes, plus random transforms: %0d transactions, %0d columns checked.",
             transforms_sent, columns_checked);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: the block stopped accepting transactions or producing columns.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
